/* design/mcsal_pkg.sv */
package mcsal_pkg;

    // Field and register widths
    localparam int SPEED_WIDTH_DEF = 18;
    localparam int CUR_W           = 16;
    localparam int LIM_W           = 17;
    localparam int FRAC_W          = 16;
    localparam int MODE_W          = 3;
    localparam int ACC_OUT_W       = 18;
    localparam int FILT_W          = 32;
    localparam int ACC_FRAC        = 14;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = LIM_W;

    // 0.1 erpm in Q.16
    localparam int TENTH_Q16 = 6554;

    // Register reset values
    localparam logic [LIM_W-1:0]  RST_SPEED_MAX  = '0;
    localparam logic [FRAC_W-1:0] RST_MODE2_FRAC = 16'd65535;
    localparam logic [FRAC_W-1:0] RST_TAPER_FRAC = 16'd52428;
    localparam logic [FRAC_W-1:0] RST_ACCEL_MAX  = 16'd65535;
    localparam logic [FRAC_W-1:0] RST_ACCEL_CUT  = 16'd65535;
    localparam logic [FRAC_W-1:0] RST_FILT_GAIN  = 16'd65535;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REVERSE_SPEED_MAX = 3'd0,
        REG_WALK_SPEED_MAX    = 3'd1,
        REG_VEHICLE_SPEED_MAX = 3'd2,
        REG_MODE_TWO_FRACTION = 3'd3,
        REG_TAPER_START_FRAC  = 3'd4,
        REG_ACCEL_MAX         = 3'd5,
        REG_ACCEL_CUT         = 3'd6,
        REG_FILTER_GAIN       = 3'd7
    } t_cfg_idx;

    // Drive mode codes
    localparam logic [MODE_W-1:0] MODE_WALK    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REDUCED = 3'd2;
    localparam logic [MODE_W-1:0] MODE_VEHICLE = 3'd3;

endpackage

/* design/mcsal_in_if.sv */
interface mcsal_in_if
    import mcsal_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [CUR_W-1:0]       current_request;
    logic signed [SPEED_WIDTH-1:0] speed_local;
    logic signed [SPEED_WIDTH-1:0] speed_remote;
    logic                          remote_valid;
    logic [MODE_W-1:0]             drive_mode;
    logic                          reverse_on;

    modport source (
        output valid, current_request, speed_local, speed_remote,
               remote_valid, drive_mode, reverse_on,
        input  ready
    );

    modport sink (
        input  valid, current_request, speed_local, speed_remote,
               remote_valid, drive_mode, reverse_on,
        output ready
    );
endinterface

/* design/mcsal_out_if.sv */
interface mcsal_out_if
    import mcsal_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [CUR_W-1:0]       current_limited;
    logic signed [SPEED_WIDTH-1:0] speed_average;
    logic                          reverse_alarm;
    logic signed [ACC_OUT_W-1:0]   accel_filtered;

    modport source (
        output valid, current_limited, speed_average, reverse_alarm, accel_filtered,
        input  ready
    );

    modport sink (
        input  valid, current_limited, speed_average, reverse_alarm, accel_filtered,
        output ready
    );
endinterface

/* design/motor_current_speed_accel_limiter_unit.sv */
// Channel  | Dir | Handshake        | Payload
// ---------+-----+------------------+------------------------------------------------
// i_req    | in  | valid / ready    | current_request, speed_local, speed_remote,
//          |     |                  | remote_valid, drive_mode, reverse_on
// o_res    | out | valid / ready    | current_limited, speed_average, reverse_alarm,
//          |     |                  | accel_filtered
// i_cfg_*  | in  | write enable     | register index, 17-bit data
//
// A new request is taken only in the idle state, after the result of the last one has
// gone to the output register. The time is set by a shared shift-add multiplier (one
// multiplier bit a cycle) and a restoring divider (one quotient bit a cycle): mode-two
// limit, taper start, each taper numerator, the filter product and each taper division
// run through them.
// Reset (synchronous, active low) clears the filter state and presets the registers.
// A result waits in the output register, so a new request is taken while it stalls.
module motor_current_speed_accel_limiter_unit
    import mcsal_pkg::*;
#(
    parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mcsal_in_if.sink              i_req,
    mcsal_out_if.source           o_res
);

    localparam int SW     = SPEED_WIDTH;
    localparam int MW     = (SW + 16 > 34) ? SW + 16 : 34;  // multiplicand
    localparam int PW     = MW + FRAC_W;                     // product
    localparam int CW     = (SW + 17 > 34) ? SW + 17 : 34;  // speed compares
    localparam int LF_W   = LIM_W + FRAC_W;                  // limit * fraction
    localparam int NUM_W  = LF_W;                            // taper num / den
    localparam int DIVD_W = NUM_W + CUR_W;                   // dividend
    localparam int CNT_W  = $clog2(FRAC_W);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_MEND = 8'b0000_0100,
        S_SPD  = 8'b0000_1000,
        S_DIFF = 8'b0001_0000,
        S_ACC  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    typedef enum logic [2:0] {
        OP_LIM   = 3'd0,
        OP_START = 3'd1,
        OP_SNUM  = 3'd2,
        OP_FLT   = 3'd3,
        OP_ANUM  = 3'd4
    } t_op;

    // Configuration registers
    logic [LIM_W-1:0]  r_rev_max, r_walk_max, r_veh_max;
    logic [FRAC_W-1:0] r_m2_frac, r_tsf, r_acc_max, r_acc_cut, r_gain;

    // Control and state
    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_ovalid, n_ovalid;
    logic signed [SW-1:0]     r_prev, n_prev;
    logic signed [FILT_W-1:0] r_v, n_v;

    // Datapath
    logic signed [MW-1:0] r_mcand, n_mcand;
    logic [FRAC_W-1:0]    r_mplier, n_mplier;
    logic signed [PW-1:0] r_acc, n_acc;
    logic [NUM_W:0]       r_rem, n_rem;
    logic [CUR_W-1:0]     r_nlo, n_nlo;
    logic [NUM_W-1:0]     r_den, n_den;
    logic [LIM_W-1:0]     r_lim, n_lim;
    logic [LF_W-1:0]      r_lf, n_lf;
    logic signed [SW-1:0] r_avg, n_avg;
    logic [SW-1:0]        r_amag, n_amag;
    logic                 r_neg, n_neg;
    logic [CUR_W-1:0]     r_cmag, n_cmag;
    logic                 r_alarm, n_alarm;

    // Output register
    logic signed [CUR_W-1:0]     r_o_cur, n_o_cur;
    logic signed [SW-1:0]        r_o_avg, n_o_avg;
    logic                        r_o_alarm, n_o_alarm;
    logic signed [ACC_OUT_W-1:0] r_o_acc, n_o_acc;

    // Combinational helpers
    logic                 accept;
    logic [SW:0]          sum_in;
    logic [SW-1:0]        avg_in;
    logic [SW-1:0]        amag_in;
    logic                 pos_in;
    logic [LIM_W-1:0]     lim_in;
    logic                 need_m2;
    logic [CUR_W-1:0]     cmag_in;
    logic                 out_load;
    logic [CW-1:0]        a16, a16_hi, st16, lim16, snum;
    logic [SW:0]          omega;
    logic [MW-1:0]        diff;
    logic [MW:0]          vsum;
    logic [MW-31:0]       vtop;
    logic [FILT_W-2:0]    v31, cut31, max31;
    logic [NUM_W:0]       dtry;
    logic                 dge;

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Speed mean, its magnitude and the limit on its side
    always_comb begin
        sum_in  = {i_req.speed_local[SW-1], i_req.speed_local}
                + {i_req.speed_remote[SW-1], i_req.speed_remote};
        avg_in  = i_req.remote_valid ? sum_in[SW:1] : i_req.speed_local;
        amag_in = avg_in[SW-1] ? (~avg_in + 1'b1) : avg_in;
        pos_in  = !avg_in[SW-1];
        cmag_in = i_req.current_request[CUR_W-1] ? (~i_req.current_request + 1'b1)
                                                 : i_req.current_request;
        need_m2 = pos_in && !i_req.reverse_on && (i_req.drive_mode == MODE_REDUCED);
        lim_in  = '0;
        if (pos_in) begin
            if (!i_req.reverse_on) begin
                if (i_req.drive_mode >= MODE_VEHICLE) begin
                    lim_in = r_veh_max;
                end else if (i_req.drive_mode == MODE_WALK) begin
                    lim_in = r_walk_max;
                end
            end
        end else if (i_req.reverse_on && i_req.drive_mode > MODE_WALK) begin
            lim_in = r_rev_max;
        end
    end

    // Speed taper bounds in Q.16
    always_comb begin
        a16    = CW'({r_amag, 16'b0});
        a16_hi = a16 + CW'(TENTH_Q16);
        st16   = CW'(r_lf) + CW'(TENTH_Q16);
        lim16  = CW'({r_lim, 16'b0});
        snum   = lim16 - a16;
    end

    // Speed change minus filter value, and the filter update with saturation
    always_comb begin
        omega = {r_avg[SW-1], r_avg} - {r_prev[SW-1], r_prev};
        diff  = ({{(MW-SW-1){omega[SW]}}, omega} << ACC_FRAC)
              - {{(MW-FILT_W){r_v[FILT_W-1]}}, r_v};
        vsum  = {{(MW+1-FILT_W){r_v[FILT_W-1]}}, r_v}
              + {r_acc[PW-1], r_acc[PW-1:FRAC_W]};
        vtop  = vsum[MW:FILT_W-1];
    end

    // Acceleration bounds, filter known not negative where used
    always_comb begin
        v31   = r_v[FILT_W-2:0];
        cut31 = (FILT_W-1)'({r_acc_cut, {ACC_FRAC{1'b0}}});
        max31 = (FILT_W-1)'({r_acc_max, {ACC_FRAC{1'b0}}});
    end

    // Restoring divider step
    always_comb begin
        dtry = {r_rem[NUM_W-1:0], r_nlo[CUR_W-1]};
        dge  = (dtry >= {1'b0, r_den});
    end

    assign out_load = (r_state == S_DONE) && (!r_ovalid || o_res.ready);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cnt     = r_cnt;
        n_prev    = r_prev;
        n_v       = r_v;
        n_mcand   = r_mcand;
        n_mplier  = r_mplier;
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_nlo     = r_nlo;
        n_den     = r_den;
        n_lim     = r_lim;
        n_lf      = r_lf;
        n_avg     = r_avg;
        n_amag    = r_amag;
        n_neg     = r_neg;
        n_cmag    = r_cmag;
        n_alarm   = r_alarm;
        n_ovalid  = r_ovalid && !o_res.ready;
        n_o_cur   = r_o_cur;
        n_o_avg   = r_o_avg;
        n_o_alarm = r_o_alarm;
        n_o_acc   = r_o_acc;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_avg   = avg_in;
                    n_amag  = amag_in;
                    n_neg   = i_req.current_request[CUR_W-1];
                    n_cmag  = cmag_in;
                    n_alarm = i_req.reverse_on && (i_req.drive_mode > MODE_WALK);
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = S_MUL;
                    if (need_m2) begin
                        n_mcand  = MW'(r_veh_max);
                        n_mplier = r_m2_frac;
                        n_op     = OP_LIM;
                    end else begin
                        n_lim    = lim_in;
                        n_mcand  = MW'(lim_in);
                        n_mplier = r_tsf;
                        n_op     = OP_START;
                    end
                end
            end

            // one multiplier bit a cycle, MSB first
            S_MUL: begin
                n_acc    = (r_acc <<< 1)
                         + (r_mplier[FRAC_W-1] ? {{FRAC_W{r_mcand[MW-1]}}, r_mcand} : '0);
                n_mplier = r_mplier << 1;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == {CNT_W{1'b1}}) begin
                    n_state = S_MEND;
                end
            end

            S_MEND: begin
                case (r_op)
                    OP_LIM: begin
                        n_lim    = r_acc[LF_W-1:FRAC_W];
                        n_mcand  = MW'(r_acc[LF_W-1:FRAC_W]);
                        n_mplier = r_tsf;
                        n_op     = OP_START;
                        n_acc    = '0;
                        n_cnt    = '0;
                        n_state  = S_MUL;
                    end
                    OP_START: begin
                        n_lf    = r_acc[LF_W-1:0];
                        n_state = S_SPD;
                    end
                    OP_FLT: begin
                        if ((&vtop) || !(|vtop)) begin
                            n_v = vsum[FILT_W-1:0];
                        end else if (vsum[MW]) begin
                            n_v = {1'b1, {(FILT_W-1){1'b0}}};
                        end else begin
                            n_v = {1'b0, {(FILT_W-1){1'b1}}};
                        end
                        n_prev  = r_avg;
                        n_state = S_ACC;
                    end
                    default: begin
                        // taper product ready: start the division
                        n_rem   = {1'b0, r_acc[DIVD_W-1:CUR_W]};
                        n_nlo   = r_acc[CUR_W-1:0];
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                endcase
            end

            // speed taper region
            S_SPD: begin
                if (a16 < st16) begin
                    n_state = S_DIFF;
                end else if (a16_hi > lim16) begin
                    n_cmag  = '0;
                    n_state = S_DIFF;
                end else begin
                    n_den    = NUM_W'(lim16 - CW'(r_lf));
                    n_mcand  = MW'(snum[NUM_W-1:0]);
                    n_mplier = r_cmag;
                    n_op     = OP_SNUM;
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_state  = S_MUL;
                end
            end

            S_DIFF: begin
                n_mcand  = diff;
                n_mplier = r_gain;
                n_op     = OP_FLT;
                n_acc    = '0;
                n_cnt    = '0;
                n_state  = S_MUL;
            end

            // acceleration taper region
            S_ACC: begin
                if (r_v[FILT_W-1] || (v31 < cut31)) begin
                    n_state = S_DONE;
                end else if ((v31 > max31) || (r_acc_max <= r_acc_cut)) begin
                    n_cmag  = '0;
                    n_state = S_DONE;
                end else begin
                    n_den    = NUM_W'({r_acc_max - r_acc_cut, {ACC_FRAC{1'b0}}});
                    n_mcand  = MW'(max31 - v31);
                    n_mplier = r_cmag;
                    n_op     = OP_ANUM;
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_state  = S_MUL;
                end
            end

            // one quotient bit a cycle
            S_DIV: begin
                n_rem = dge ? (dtry - {1'b0, r_den}) : dtry;
                n_nlo = {r_nlo[CUR_W-2:0], dge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == {CNT_W{1'b1}}) begin
                    n_cmag  = {r_nlo[CUR_W-2:0], dge};
                    n_state = (r_op == OP_SNUM) ? S_DIFF : S_DONE;
                end
            end

            S_DONE: begin
                if (out_load) begin
                    n_ovalid  = 1'b1;
                    n_o_cur   = r_neg ? (~r_cmag + 1'b1) : r_cmag;
                    n_o_avg   = r_avg;
                    n_o_alarm = r_alarm;
                    n_o_acc   = r_v[FILT_W-1:ACC_FRAC];
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op       <= OP_LIM;
            r_cnt      <= '0;
            r_ovalid   <= 1'b0;
            r_prev     <= '0;
            r_v        <= '0;
            r_rev_max  <= RST_SPEED_MAX;
            r_walk_max <= RST_SPEED_MAX;
            r_veh_max  <= RST_SPEED_MAX;
            r_m2_frac  <= RST_MODE2_FRAC;
            r_tsf      <= RST_TAPER_FRAC;
            r_acc_max  <= RST_ACCEL_MAX;
            r_acc_cut  <= RST_ACCEL_CUT;
            r_gain     <= RST_FILT_GAIN;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            r_prev   <= n_prev;
            r_v      <= n_v;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    REG_REVERSE_SPEED_MAX: r_rev_max  <= i_cfg_data;
                    REG_WALK_SPEED_MAX:    r_walk_max <= i_cfg_data;
                    REG_VEHICLE_SPEED_MAX: r_veh_max  <= i_cfg_data;
                    REG_MODE_TWO_FRACTION: r_m2_frac  <= i_cfg_data[FRAC_W-1:0];
                    REG_TAPER_START_FRAC:  r_tsf      <= i_cfg_data[FRAC_W-1:0];
                    REG_ACCEL_MAX:         r_acc_max  <= i_cfg_data[FRAC_W-1:0];
                    REG_ACCEL_CUT:         r_acc_cut  <= i_cfg_data[FRAC_W-1:0];
                    REG_FILTER_GAIN:       r_gain     <= i_cfg_data[FRAC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath and output payload
    always_ff @(posedge i_clk) begin
        r_mcand   <= n_mcand;
        r_mplier  <= n_mplier;
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_nlo     <= n_nlo;
        r_den     <= n_den;
        r_lim     <= n_lim;
        r_lf      <= n_lf;
        r_avg     <= n_avg;
        r_amag    <= n_amag;
        r_neg     <= n_neg;
        r_cmag    <= n_cmag;
        r_alarm   <= n_alarm;
        r_o_cur   <= n_o_cur;
        r_o_avg   <= n_o_avg;
        r_o_alarm <= n_o_alarm;
        r_o_acc   <= n_o_acc;
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.current_limited = r_o_cur;
    assign o_res.speed_average   = r_o_avg;
    assign o_res.reverse_alarm   = r_o_alarm;
    assign o_res.accel_filtered  = r_o_acc;

endmodule
